[src/assert_macros.svh]
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/ssrp_pkg.sv]
`default_nettype none
package ssrp_pkg;

  localparam logic [17:0] PI_Q16 = 18'd205887;
  localparam logic [15:0] UL_PER_VOL = 16'd40000;
  localparam logic [3:0]  VOL_SCALE = 4'd10;
  localparam logic [4:0]  STEPS_PER_MM = 5'd25;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;
  localparam logic [3:0]  K_MAX = 4'd8;
  localparam logic [63:0] Q_MAX = 64'd65536;

  localparam logic [1:0] REG_SVOL = 2'd0;
  localparam logic [1:0] REG_DIAM = 2'd1;
  localparam logic [1:0] REG_BLEN = 2'd2;
  localparam logic [1:0] REG_CLK  = 2'd3;

  typedef logic [3:0] op_t;
  localparam op_t OP_NONE   = 4'd0;
  localparam op_t OP_LOAD   = 4'd1;
  localparam op_t OP_MUL1   = 4'd2;
  localparam op_t OP_MUL2   = 4'd3;
  localparam op_t OP_GO     = 4'd4;
  localparam op_t OP_TAKE_T = 4'd5;
  localparam op_t OP_MUL3   = 4'd6;
  localparam op_t OP_MUL4   = 4'd7;
  localparam op_t OP_TAKE_Q = 4'd8;
  localparam op_t OP_TRIAL  = 4'd9;
  localparam op_t OP_ZERO   = 4'd10;

  typedef struct packed {
    logic flow_zero;
    logic src_bad;
    logic t_zero;
    logic div_done;
    logic fit;
    logic k_zero;
  } stat_t;

  typedef struct packed {
    logic [13:0] svol;
    logic [9:0]  diam;
    logic [13:0] blen;
    logic [27:0] clk_hz;
  } cfg_t;

endpackage
`default_nettype wire

[src/ssrp_div.sv]
`default_nettype none
module ssrp_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [63:0] dvd,
  input  wire logic [63:0] dsr,
  output logic             done,
  output logic [63:0]      quo
);
  import ssrp_pkg::*;

  logic        run_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r;
  logic [63:0] quo_r;
  logic [63:0] dsr_r;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        take;

  assign trial = {rem_r, quo_r[63]};
  assign diff  = trial - {1'b0, dsr_r};
  assign take  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= dvd;
      dsr_r <= dsr;
    end else if (run_r) begin
      rem_r <= take ? diff[63:0] : trial[63:0];
      quo_r <= {quo_r[62:0], take};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

[src/ssrp_dp.sv]
`default_nettype none
module ssrp_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ssrp_pkg::op_t  op,
  input  wire ssrp_pkg::cfg_t cfg,
  input  wire logic [13:0]    vol_in,
  input  wire logic [13:0]    flow_in,
  output ssrp_pkg::stat_t     stat,
  output logic                out_valid,
  output logic [31:0]         out_total_steps,
  output logic [15:0]         out_reload,
  output logic [8:0]          out_microsteps,
  output logic                out_ok
);
  import ssrp_pkg::*;

  logic [13:0] v_r;
  logic [13:0] f_r;
  logic [19:0] p1_r;
  logic [29:0] p2_r;
  logic [41:0] cv_r;
  logic [31:0] t_r;
  logic [36:0] t25_r;
  logic [47:0] num_r;
  logic [63:0] q1_r;
  logic [3:0]  k_r;
  logic [63:0] dvd_r;
  logic [63:0] dsr_r;
  logic        val_r;
  logic [31:0] steps_r;
  logic [15:0] rel_r;
  logic [8:0]  ms_r;
  logic        ok_r;

  logic        div_done;
  logic [63:0] div_quo;
  logic [44:0] sh;
  logic [28:0] whole;
  logic [63:0] qk;
  logic [63:0] qm1;
  logic        fit;

  ssrp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (op == OP_GO),
    .dvd  (dvd_r),
    .dsr  (dsr_r),
    .done (div_done),
    .quo  (div_quo)
  );

  assign sh    = {8'b0, t25_r} << k_r;
  assign whole = sh[44:16];
  assign qk    = q1_r >> k_r;
  assign qm1   = qk - 64'd1;
  assign fit   = (whole != '0) && (qk != '0) && (qk <= Q_MAX);

  assign stat.flow_zero = (f_r == '0);
  assign stat.src_bad   = (cfg.diam == '0) && (cfg.svol == '0);
  assign stat.t_zero    = (t_r == '0);
  assign stat.div_done  = div_done;
  assign stat.fit       = fit;
  assign stat.k_zero    = (k_r == '0);

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        v_r <= vol_in;
        f_r <= flow_in;
      end
      OP_MUL1: begin
        if (cfg.diam != '0) begin
          p1_r <= cfg.diam * cfg.diam;
          p2_r <= v_r * UL_PER_VOL;
        end else begin
          p1_r <= 20'(cfg.svol * VOL_SCALE);
          p2_r <= 30'(v_r * cfg.blen);
        end
        cv_r <= cfg.clk_hz * v_r;
      end
      OP_MUL2: begin
        if (cfg.diam != '0) begin
          dsr_r <= {26'b0, 38'(p1_r) * PI_Q16};
          dvd_r <= {2'b0, p2_r, 32'b0};
        end else begin
          dsr_r <= {44'b0, p1_r};
          dvd_r <= {20'b0, p2_r[27:0], 16'b0};
        end
      end
      OP_TAKE_T: t_r <= (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
      OP_MUL3: begin
        t25_r <= t_r * STEPS_PER_MM;
        num_r <= cv_r * SEC_PER_MIN;
      end
      OP_MUL4: begin
        dsr_r <= {13'b0, 51'(t25_r) * f_r};
        dvd_r <= {num_r, 16'b0};
      end
      OP_TAKE_Q: q1_r <= div_quo;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
      k_r   <= '0;
    end else begin
      val_r <= 1'b0;
      if (op == OP_TAKE_Q) begin
        k_r <= K_MAX;
      end else if (op == OP_ZERO) begin
        val_r <= 1'b1;
      end else if (op == OP_TRIAL) begin
        if (fit || k_r == '0) begin
          val_r <= 1'b1;
        end else begin
          k_r <= k_r - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_ZERO || (op == OP_TRIAL && !fit && k_r == '0)) begin
      steps_r <= '0;
      rel_r   <= '0;
      ms_r    <= '0;
      ok_r    <= 1'b0;
    end else if (op == OP_TRIAL && fit) begin
      steps_r <= {3'b0, whole};
      rel_r   <= qm1[15:0];
      ms_r    <= 9'd1 << k_r;
      ok_r    <= 1'b1;
    end
  end

  assign out_valid       = val_r;
  assign out_total_steps = steps_r;
  assign out_reload      = rel_r;
  assign out_microsteps  = ms_r;
  assign out_ok          = ok_r;

endmodule
`default_nettype wire

[src/ssrp_ctrl.sv]
`default_nettype none
module ssrp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire ssrp_pkg::stat_t stat,
  output ssrp_pkg::op_t        op,
  output logic                 busy
);
  import ssrp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_GO1   = 4'd3;
  localparam logic [3:0] S_WAIT1 = 4'd4;
  localparam logic [3:0] S_MUL3  = 4'd5;
  localparam logic [3:0] S_MUL4  = 4'd6;
  localparam logic [3:0] S_GO2   = 4'd7;
  localparam logic [3:0] S_WAIT2 = 4'd8;
  localparam logic [3:0] S_TRIAL = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op        = OP_LOAD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.flow_zero || stat.src_bad) begin
          op        = OP_ZERO;
          state_nxt = S_IDLE;
        end else begin
          op        = OP_MUL1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        op        = OP_MUL2;
        state_nxt = S_GO1;
      end
      S_GO1: begin
        op        = OP_GO;
        state_nxt = S_WAIT1;
      end
      S_WAIT1: begin
        if (stat.div_done) begin
          op        = OP_TAKE_T;
          state_nxt = S_MUL3;
        end
      end
      S_MUL3: begin
        if (stat.t_zero) begin
          op        = OP_ZERO;
          state_nxt = S_IDLE;
        end else begin
          op        = OP_MUL3;
          state_nxt = S_MUL4;
        end
      end
      S_MUL4: begin
        op        = OP_MUL4;
        state_nxt = S_GO2;
      end
      S_GO2: begin
        op        = OP_GO;
        state_nxt = S_WAIT2;
      end
      S_WAIT2: begin
        if (stat.div_done) begin
          op        = OP_TAKE_Q;
          state_nxt = S_TRIAL;
        end
      end
      S_TRIAL: begin
        op = OP_TRIAL;
        if (stat.fit || stat.k_zero) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

[src/syringe_step_rate_planner_top.sv]
// Syringe step-rate planner. Pulse start while busy is low to hand in one
// item; exactly one result follows, shown for a single cycle with out_valid
// high. The receiver cannot stall, so capture it in that cycle. out_valid is
// raised straight after the check state when flow is zero or the length method
// has no syringe volume, after the first divider pass when the travel is zero,
// else after the second pass and the microstep trials: two passes of the shared
// radix-2 divider set the figure, then factors are tried in turn, largest first.
// busy drops with out_valid; the next start is taken that same cycle.
// Write configuration only while busy is low.
`default_nettype none
module syringe_step_rate_planner_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [13:0] in_dispense_volume,
  input  wire logic [13:0] in_flow_rate,
  output logic             out_valid,
  output logic [31:0]      out_total_steps,
  output logic [15:0]      out_reload,
  output logic [8:0]       out_microsteps,
  output logic             out_ok,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ssrp_pkg::*;

  cfg_t  cfg_r;
  op_t   op;
  stat_t stat;
  logic  wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.svol   <= '0;
      cfg_r.diam   <= '0;
      cfg_r.blen   <= '0;
      cfg_r.clk_hz <= 28'd72000000;
    end else if (wr) begin
      case (paddr[3:2])
        REG_SVOL: cfg_r.svol   <= pwdata[13:0];
        REG_DIAM: cfg_r.diam   <= pwdata[9:0];
        REG_BLEN: cfg_r.blen   <= pwdata[13:0];
        REG_CLK:  cfg_r.clk_hz <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SVOL: prdata = {18'b0, cfg_r.svol};
      REG_DIAM: prdata = {22'b0, cfg_r.diam};
      REG_BLEN: prdata = {18'b0, cfg_r.blen};
      REG_CLK:  prdata = {4'b0, cfg_r.clk_hz};
      default:  prdata = '0;
    endcase
  end

  ssrp_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .op   (op),
    .busy (busy)
  );

  ssrp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .cfg            (cfg_r),
    .vol_in         (in_dispense_volume),
    .flow_in        (in_flow_rate),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_total_steps(out_total_steps),
    .out_reload     (out_reload),
    .out_microsteps (out_microsteps),
    .out_ok         (out_ok)
  );

endmodule
`default_nettype wire

[src/ssrp_chk.sv]
`default_nettype none
module ssrp_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [31:0] out_total_steps,
  input wire logic [15:0] out_reload,
  input wire logic [8:0]  out_microsteps,
  input wire logic        out_ok
);
`include "assert_macros.svh"

  logic plan_zero;

  assign plan_zero = (out_total_steps == 32'd0) && (out_reload == 16'd0) &&
                     (out_microsteps == 9'd0);

  `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ASSERT_NOW(a_result_idle, out_valid, !busy)
  `ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `ASSERT_NOW(a_fail_zero, out_valid && !out_ok, plan_zero)
  `ASSERT_NOW(a_ok_plan, out_valid && out_ok, $onehot(out_microsteps) && out_total_steps != 32'd0)

endmodule

bind syringe_step_rate_planner_top ssrp_chk u_chk (.*);
`default_nettype wire
